// ----- rtl/mksd_pkg.sv -----
// Package for the matrix keypad scanner: field widths, defaults, result type, helpers.
`default_nettype none
package mksd_pkg;

    // Fixed field widths
    localparam int ROW_W  = 4;
    localparam int DRV_W  = 4;
    localparam int KEY_W  = 16;
    localparam int REG_W  = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // Register indexes
    localparam logic REG_SETTLE = 1'b0;
    localparam logic REG_REPEAT = 1'b1;

    // Register reset values
    localparam logic [REG_W-1:0] SETTLE_RST = 8'd3;
    localparam logic [REG_W-1:0] REPEAT_RST = 8'd3;

    // Parameter defaults
    localparam int NUM_ROWS_DEF    = 4;
    localparam int NUM_COLUMNS_DEF = 4;

    // Status codes
    localparam logic STAT_STABLE   = 1'b0;
    localparam logic STAT_UNSTABLE = 1'b1;

    // One result item
    typedef struct packed {
        logic             status;
        logic [KEY_W-1:0] key_state;
        logic             done_res;
        logic             busy_res;
        logic [DRV_W-1:0] column_drive;
    } t_result;

    // Drive bit for one column; columns past the drive field have none
    function automatic logic [DRV_W-1:0] col_bit(input int col);
        logic [DRV_W-1:0] m;
        m = '0;
        if (col < DRV_W) begin
            m = DRV_W'(1) << col;
        end
        return m;
    endfunction

    // All columns of the keypad high, limited to the drive field
    function automatic logic [DRV_W-1:0] all_high(input int ncols);
        logic [DRV_W-1:0] m;
        m = '0;
        for (int n = 0; n < DRV_W; n++) begin
            if (n < ncols) begin
                m[n] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/mksd_scan_core.sv -----
// Scan state and the single-tick update that forms one result item.
`default_nettype none
module mksd_scan_core #(
    parameter int NUM_ROWS    = mksd_pkg::NUM_ROWS_DEF,
    parameter int NUM_COLUMNS = mksd_pkg::NUM_COLUMNS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_addr,
    input  wire logic [mksd_pkg::REG_W-1:0]   i_cfg_wdata,
    input  wire logic                         i_advance,
    input  wire logic                         i_start_req,
    input  wire logic [mksd_pkg::ROW_W-1:0]   i_row_levels,
    output mksd_pkg::t_result                 o_result
);

    localparam int CIW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam int KW  = mksd_pkg::KEY_W;
    localparam int RW  = mksd_pkg::REG_W;

    logic [RW-1:0]   r_settle, r_repeat;
    logic            r_scanning, n_scanning;
    logic [CIW-1:0]  r_col, n_col;
    logic [RW-1:0]   r_cnt, n_cnt;
    logic [KW-1:0]   r_acc, n_acc;
    logic [KW-1:0]   r_prev, n_prev;
    logic [RW-1:0]   r_scans, n_scans;
    logic [mksd_pkg::DRV_W-1:0] r_drive, n_drive;

    logic [RW:0]     cnt_inc;
    logic [RW-1:0]   limit;
    logic [KW-1:0]   sampled;
    logic            done;
    logic [KW-1:0]   key;
    logic            stat;

    // Hold the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= mksd_pkg::SETTLE_RST;
            r_repeat <= mksd_pkg::REPEAT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                mksd_pkg::REG_SETTLE: r_settle <= i_cfg_wdata;
                mksd_pkg::REG_REPEAT: r_repeat <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Merge the rows of the current column into the scan map
    always_comb begin
        int pos;
        sampled = r_acc;
        for (int m = 0; m < NUM_ROWS && m < mksd_pkg::ROW_W; m++) begin
            pos = mksd_pkg::ROW_W * int'(r_col) + m;
            if (i_row_levels[m] && pos < KW) begin
                sampled = sampled | (KW'(1) << pos);
            end
        end
    end

    // Advance the scan by one tick
    always_comb begin
        n_scanning = r_scanning;
        n_col      = r_col;
        n_cnt      = r_cnt;
        n_acc      = r_acc;
        n_prev     = r_prev;
        n_scans    = r_scans;
        n_drive    = r_drive;
        done       = 1'b0;
        key        = '0;
        stat       = mksd_pkg::STAT_STABLE;
        limit      = (r_settle == '0) ? RW'(1) : r_settle;
        cnt_inc    = {1'b0, r_cnt} + (RW+1)'(1);
        if (!r_scanning) begin
            if (i_start_req) begin
                n_scanning = 1'b1;
                n_col      = '0;
                n_cnt      = '0;
                n_acc      = '0;
                n_prev     = '0;
                n_scans    = '0;
                n_drive    = mksd_pkg::col_bit(0);
            end
        end else if (cnt_inc < {1'b0, limit}) begin
            n_cnt = cnt_inc[RW-1:0];
        end else begin
            n_cnt = '0;
            n_acc = sampled;
            if (int'(r_col) + 1 < NUM_COLUMNS) begin
                n_col   = r_col + CIW'(1);
                n_drive = mksd_pkg::col_bit(int'(r_col) + 1);
            end else begin
                if (r_scans != '1) begin
                    n_scans = r_scans + RW'(1);
                end
                if (r_repeat <= RW'(1)) begin
                    done = 1'b1;
                    key  = sampled;
                end else if (n_scans >= RW'(2) && sampled == r_prev) begin
                    done = 1'b1;
                    key  = sampled;
                end else if (n_scans >= r_repeat) begin
                    done = 1'b1;
                    stat = mksd_pkg::STAT_UNSTABLE;
                end else begin
                    n_prev  = sampled;
                    n_acc   = '0;
                    n_col   = '0;
                    n_drive = mksd_pkg::col_bit(0);
                end
                if (done) begin
                    n_scanning = 1'b0;
                    n_col      = '0;
                    n_drive    = mksd_pkg::all_high(NUM_COLUMNS);
                end
            end
        end
    end

    // Commit the state on an accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scanning <= 1'b0;
            r_col      <= '0;
            r_cnt      <= '0;
            r_acc      <= '0;
            r_prev     <= '0;
            r_scans    <= '0;
            r_drive    <= '0;
        end else if (i_advance) begin
            r_scanning <= n_scanning;
            r_col      <= n_col;
            r_cnt      <= n_cnt;
            r_acc      <= n_acc;
            r_prev     <= n_prev;
            r_scans    <= n_scans;
            r_drive    <= n_drive;
        end
    end

    // Form the result item for this tick
    always_comb begin
        o_result.column_drive = n_drive;
        o_result.busy_res     = n_scanning;
        o_result.done_res     = done;
        o_result.key_state    = key;
        o_result.status       = stat;
    end

endmodule
`default_nettype wire

// ----- rtl/mksd_out_reg.sv -----
// Output register for result items, ready whenever it is empty or being drained.
`default_nettype none
module mksd_out_reg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_load,
    input  wire mksd_pkg::t_result                 i_result,
    output logic                                   o_ready,
    output logic                                   o_tvalid,
    input  wire logic                              i_tready,
    output logic [mksd_pkg::OUT_TDATA_W-1:0]       o_tdata
);

    localparam int RES_W = $bits(mksd_pkg::t_result);

    logic              r_valid;
    mksd_pkg::t_result r_data;

    assign o_ready = !r_valid || i_tready;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    // Capture the payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_data <= i_result;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {(mksd_pkg::OUT_TDATA_W - RES_W)'(0), r_data};

endmodule
`default_nettype wire

// ----- rtl/matrix_keypad_scan_debounce.sv -----
// Top level of the debounced matrix keypad scanner.
//
// Input stream: one item per timing tick carrying start_req and the sampled
// row pin levels. Output stream: one result item per input item with the
// column drive levels for the next tick, busy, done, the key map and status.
// Configuration: i_cfg_we with i_cfg_addr 0 writes settle_ticks, 1 writes
// repeat_count; write only while idle.
// An item accepted at an edge yields its result in the output register at
// that same edge. Throughput is one item per cycle while the receiver does
// not stall; the scan state updates combinationally between the input and
// the output register.
// Reset clears the scan state (idle, columns low), empties the output
// register and loads settle_ticks = 3 and repeat_count = 3.
// When the receiver stalls, the output register holds its item and
// s_axis_tready drops until that item is taken; an item is accepted
// together with the one leaving.
`default_nettype none
module matrix_keypad_scan_debounce #(
    parameter int NUM_ROWS    = mksd_pkg::NUM_ROWS_DEF,
    parameter int NUM_COLUMNS = mksd_pkg::NUM_COLUMNS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration writes
    input  wire logic                                i_cfg_we,
    input  wire logic                                i_cfg_addr,
    input  wire logic [mksd_pkg::REG_W-1:0]          i_cfg_wdata,
    // Input items
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [0] start_req, [4:1] row_levels, [7:5] zero
    input  wire logic [mksd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Result items
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [3:0] column_drive, [4] busy_res, [5] done_res, [21:6] key_state,
    // [22] status, [23] zero
    output logic [mksd_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

    logic              accept;
    logic              out_ready;
    mksd_pkg::t_result result;

    assign s_axis_tready = out_ready;
    assign accept        = s_axis_tvalid && out_ready;

    // Scan state and single-tick update
    mksd_scan_core #(
        .NUM_ROWS    (NUM_ROWS),
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_advance    (accept),
        .i_start_req  (s_axis_tdata[0]),
        .i_row_levels (s_axis_tdata[mksd_pkg::ROW_W:1]),
        .o_result     (result)
    );

    // Result register
    mksd_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_result (result),
        .o_ready  (out_ready),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );

endmodule
`default_nettype wire

// ----- tb/sv/matrix_keypad_scan_debounce_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the debounced matrix keypad scanner: directed and random scans.

module matrix_keypad_scan_debounce_test;
    import mksd_pkg::*;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int RANDOM_TICKS    = 750;
    localparam logic [DRV_W-1:0] DRIVE_COL0 = 4'b0001;
    localparam logic [DRV_W-1:0] DRIVE_ALL  = 4'b1111;
    localparam logic [1:0]       LAST_COL   = 2'd3;

    // How the row pins behave over one request
    typedef enum int {
        KEYS_STEADY,
        KEYS_SETTLING,
        KEYS_NOISY,
        KEYS_FLICKER
    } t_key_pattern;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic                   i_cfg_addr    = REG_SETTLE;
    logic [REG_W-1:0]       i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Scanner mirror: configuration and scan state
    logic [REG_W-1:0] cfg_settle = SETTLE_RST;
    logic [REG_W-1:0] cfg_repeat = REPEAT_RST;
    logic             sc_busy       = 1'b0;
    logic [1:0]       sc_col        = '0;
    logic [7:0]       sc_settle_cnt = '0;
    logic [KEY_W-1:0] sc_acc        = '0;
    logic [KEY_W-1:0] sc_prev       = '0;
    logic [7:0]       sc_scans      = '0;
    logic [DRV_W-1:0] sc_drive      = '0;

    t_result expected_reports[$];
    int      fail_cnt    = 0;
    int      ticks_sent  = 0;
    int      idle_cycles = 0;
    int      stall_left  = 0;
    bit      quiet_in    = 1'b0;
    bit      quiet_out   = 1'b0;

    matrix_keypad_scan_debounce u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Pause length: mostly none, some short, a few long
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    // Advance the scanner mirror by one tick and return the report it gives
    function automatic t_result advance_scanner(input logic start, input logic [ROW_W-1:0] rows);
        t_result r;
        int      window;
        r = '0;
        if (!sc_busy) begin
            if (start) begin
                sc_busy       = 1'b1;
                sc_col        = '0;
                sc_settle_cnt = '0;
                sc_acc        = '0;
                sc_prev       = '0;
                sc_scans      = '0;
                sc_drive      = DRIVE_COL0;
            end
        end else begin
            window = (cfg_settle == 0) ? 1 : int'(cfg_settle);
            if (int'(sc_settle_cnt) + 1 < window) begin
                sc_settle_cnt = sc_settle_cnt + 8'd1;
            end else begin
                // Sample the rows of the driven column
                sc_settle_cnt = '0;
                sc_acc[4*sc_col +: ROW_W] = sc_acc[4*sc_col +: ROW_W] | rows;
                if (sc_col != LAST_COL) begin
                    sc_col   = sc_col + 2'd1;
                    sc_drive = DRIVE_COL0 << sc_col;
                end else begin
                    if (sc_scans != 8'hFF) begin
                        sc_scans = sc_scans + 8'd1;
                    end
                    if (cfg_repeat <= 1) begin
                        r.done_res  = 1'b1;
                        r.key_state = sc_acc;
                        r.status    = STAT_STABLE;
                    end else if (sc_scans >= 2 && sc_acc == sc_prev) begin
                        r.done_res  = 1'b1;
                        r.key_state = sc_acc;
                        r.status    = STAT_STABLE;
                    end else if (sc_scans >= cfg_repeat) begin
                        r.done_res = 1'b1;
                        r.status   = STAT_UNSTABLE;
                    end else begin
                        sc_prev  = sc_acc;
                        sc_acc   = '0;
                        sc_col   = '0;
                        sc_drive = DRIVE_COL0;
                    end
                    if (r.done_res) begin
                        sc_busy  = 1'b0;
                        sc_col   = '0;
                        sc_drive = DRIVE_ALL;
                    end
                end
            end
        end
        r.column_drive = sc_drive;
        r.busy_res     = sc_busy;
        return r;
    endfunction

    // Send one tick item, wait for its handshake and queue its report
    task automatic send_tick(input logic start, input logic [ROW_W-1:0] rows);
        int gap;
        gap = quiet_in ? 0 : pick_pause();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - 1 - ROW_W){1'b0}}, rows, start};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (sc_busy || start) begin
            ticks_sent++;
        end
        expected_reports.push_back(advance_scanner(start, rows));
    endtask

    task automatic stop_ticks();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold off until every queued report has come back
    task automatic wait_reports();
        stop_ticks();
        while (expected_reports.size() != 0) @(posedge i_clk);
    endtask

    // Finish any request in flight, then let the block go quiet
    task automatic settle_idle();
        while (sc_busy) begin
            send_tick(1'b0, ROW_W'($urandom_range(0, 15)));
        end
        wait_reports();
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic addr, input logic [REG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        if (addr == REG_SETTLE) begin
            cfg_settle = value;
        end else begin
            cfg_repeat = value;
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [REG_W-1:0] settle, input logic [REG_W-1:0] repeats);
        settle_idle();
        write_reg(REG_SETTLE, settle);
        write_reg(REG_REPEAT, repeats);
    endtask

    task automatic idle_ticks(input int n);
        repeat (n) send_tick(1'b0, ROW_W'($urandom_range(0, 15)));
    endtask

    // Start one request and feed row levels until it finishes
    task automatic run_request(input t_key_pattern pattern, input logic [KEY_W-1:0] key_map,
                               input bit hold_start);
        logic [KEY_W-1:0] scan_map;
        logic [ROW_W-1:0] rows;
        int               last_scans;
        int               noisy_scans;
        bit               sample_tick;
        send_tick(1'b1, ROW_W'($urandom_range(0, 15)));
        noisy_scans = $urandom_range(1, 3);
        scan_map    = (pattern == KEYS_NOISY || pattern == KEYS_SETTLING) ?
                      KEY_W'($urandom) : key_map;
        last_scans  = 0;
        while (sc_busy) begin
            // Pick a fresh map when a new scan begins
            if (int'(sc_scans) != last_scans) begin
                last_scans = int'(sc_scans);
                if (pattern == KEYS_NOISY ||
                    (pattern == KEYS_SETTLING && last_scans < noisy_scans)) begin
                    scan_map = KEY_W'($urandom);
                end else begin
                    scan_map = key_map;
                end
            end
            sample_tick = int'(sc_settle_cnt) + 1 >= ((cfg_settle == 0) ? 1 : int'(cfg_settle));
            rows = scan_map[4*sc_col +: ROW_W];
            if (pattern == KEYS_FLICKER && $urandom_range(0, 9) == 0) begin
                rows[$urandom_range(0, ROW_W - 1)] ^= 1'b1;
            end
            // Pins may wander while the column settles
            if (!sample_tick && $urandom_range(0, 3) == 0) begin
                rows = ROW_W'($urandom_range(0, 15));
            end
            send_tick(hold_start || ($urandom_range(0, 7) == 0), rows);
        end
    endtask

    task automatic test_reset_defaults();
        send_tick(1'b0, 4'h0);
        send_tick(1'b0, 4'hF);
        run_request(KEYS_STEADY, 16'h8421, 1'b0);
    endtask

    task automatic test_single_scan();
        configure(8'd1, 8'd0);
        run_request(KEYS_STEADY, 16'hFFFF, 1'b0);
        run_request(KEYS_STEADY, 16'h0000, 1'b0);
        configure(8'd1, 8'd1);
        run_request(KEYS_NOISY, 16'h0000, 1'b0);
    endtask

    task automatic test_debounce_match();
        configure(8'd1, 8'd2);
        run_request(KEYS_STEADY, 16'h5AA5, 1'b0);
        configure(8'd2, 8'd4);
        run_request(KEYS_SETTLING, 16'h1234, 1'b0);
    endtask

    task automatic test_bouncing();
        configure(8'd1, 8'd3);
        run_request(KEYS_NOISY, 16'h0000, 1'b0);
    endtask

    task automatic test_start_while_busy();
        configure(8'd1, 8'd2);
        run_request(KEYS_STEADY, 16'hC3C3, 1'b1);
        run_request(KEYS_STEADY, 16'h3C3C, 1'b1);
    endtask

    task automatic test_settle_zero();
        configure(8'd0, 8'd2);
        run_request(KEYS_STEADY, 16'hF00F, 1'b0);
    endtask

    task automatic test_register_extremes();
        configure(8'd40, 8'd1);
        run_request(KEYS_STEADY, KEY_W'($urandom), 1'b0);
        configure(8'd1, 8'd255);
        run_request(KEYS_SETTLING, 16'h0F0F, 1'b0);
    endtask

    task automatic test_random_traffic();
        int           target;
        int           req_cnt;
        t_key_pattern pattern;
        logic [7:0]   settle;
        logic [7:0]   repeats;
        target  = ticks_sent + RANDOM_TICKS;
        req_cnt = 0;
        while (ticks_sent < target) begin
            // Change settings and idling style every eight requests
            if (req_cnt % 8 == 0) begin
                settle  = ($urandom_range(0, 9) == 0) ? 8'd8 : 8'($urandom_range(1, 4));
                repeats = ($urandom_range(0, 9) == 0) ? 8'd12 : 8'($urandom_range(0, 6));
                configure(settle, repeats);
                quiet_in  = ($urandom_range(0, 3) == 0);
                quiet_out = ($urandom_range(0, 3) == 0);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: pattern = KEYS_STEADY;
                5, 6:          pattern = KEYS_SETTLING;
                7:             pattern = KEYS_FLICKER;
                default:       pattern = KEYS_NOISY;
            endcase
            run_request(pattern, KEY_W'($urandom), $urandom_range(0, 15) == 0);
            idle_ticks($urandom_range(0, 3));
            if ($urandom_range(0, 19) == 0) begin
                wait_reports();
            end
            req_cnt++;
        end
        quiet_in  = 1'b0;
        quiet_out = 1'b0;
    endtask

    // Receiver: accept results with random stalls
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (!quiet_out && $urandom_range(0, 99) < 25) begin
            m_axis_tready <= 1'b0;
            stall_left = pick_pause();
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest queued report
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[$bits(t_result)-1:0];
            if (expected_reports.size() == 0) begin
                $error("result item with no report pending: %h", m_axis_tdata);
                fail_cnt++;
            end else begin
                want = expected_reports.pop_front();
                if (got.column_drive !== want.column_drive) begin
                    $error("column_drive: expected %h, actual %h",
                           want.column_drive, got.column_drive);
                    fail_cnt++;
                end
                if (got.busy_res !== want.busy_res) begin
                    $error("busy_res: expected %b, actual %b", want.busy_res, got.busy_res);
                    fail_cnt++;
                end
                if (got.done_res !== want.done_res) begin
                    $error("done_res: expected %b, actual %b", want.done_res, got.done_res);
                    fail_cnt++;
                end
                if (got.key_state !== want.key_state) begin
                    $error("key_state: expected %h, actual %h", want.key_state, got.key_state);
                    fail_cnt++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %b, actual %b", want.status, got.status);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: end the run when no item moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_single_scan();
        test_debounce_match();
        test_bouncing();
        test_start_while_busy();
        test_settle_zero();
        test_register_extremes();
        test_random_traffic();
        settle_idle();
        repeat (8) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/mksd_pkg.sv
rtl/mksd_scan_core.sv
rtl/mksd_out_reg.sv
rtl/matrix_keypad_scan_debounce.sv
tb/sv/matrix_keypad_scan_debounce_test.sv
